// ----- sv/countdown_time_difference_split_top_defines.svh -----
// Assertion macros for the countdown time difference splitter.
`ifndef COUNTDOWN_TIME_DIFFERENCE_SPLIT_TOP_DEFINES_SVH
`define COUNTDOWN_TIME_DIFFERENCE_SPLIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDTS_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("cdts: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDTS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("cdts: next-cycle check failed");

`endif

// ----- sv/cdts_pkg.sv -----
// Shared types, constants and helper functions of the countdown time difference splitter.
package cdts_pkg;

    // Time unit constants
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [10:0] MIN_PER_HOUR = 11'd60;

    // Calendar offsets: years are biased by 400 so the day count stays non-negative
    localparam logic [12:0]        YEAR_BIAS = 13'd400;
    localparam logic signed [21:0] DAY_BIAS  = 22'sd865566;

    // Configuration register indexes
    localparam logic [2:0] REG_DISPLAY_MODE  = 3'd0;
    localparam logic [2:0] REG_TARGET_YEAR   = 3'd1;
    localparam logic [2:0] REG_TARGET_MONTH  = 3'd2;
    localparam logic [2:0] REG_TARGET_DAY    = 3'd3;
    localparam logic [2:0] REG_TARGET_HOUR   = 3'd4;
    localparam logic [2:0] REG_TARGET_MINUTE = 3'd5;
    localparam logic [2:0] REG_TARGET_SECOND = 3'd6;

    // Display mode codes
    localparam logic [4:0] MODE_DHMS_LO = 5'd0;
    localparam logic [4:0] MODE_DHMS_HI = 5'd2;
    localparam logic [4:0] MODE_DHM_LO  = 5'd3;
    localparam logic [4:0] MODE_DHM_HI  = 5'd5;
    localparam logic [4:0] MODE_DH_LO   = 5'd6;
    localparam logic [4:0] MODE_DH_HI   = 5'd8;
    localparam logic [4:0] MODE_D_LO    = 5'd9;
    localparam logic [4:0] MODE_D_HI    = 5'd11;
    localparam logic [4:0] MODE_HMS     = 5'd12;
    localparam logic [4:0] MODE_HM      = 5'd13;
    localparam logic [4:0] MODE_H       = 5'd14;
    localparam logic [4:0] MODE_MS      = 5'd15;
    localparam logic [4:0] MODE_M       = 5'd16;
    localparam logic [4:0] MODE_S       = 5'd17;

    // One instant: signed day number since 1970 plus seconds into that day
    typedef struct packed {
        logic signed [21:0] days;
        logic [16:0]        sod;
    } stamp_t;

    // floor(v / 100) for v below 8192 by reciprocal multiply
    function automatic logic [6:0] div100(input logic [12:0] v);
        logic [25:0] prod;
        prod = 26'(v) * 26'd5243;
        return prod[25:19];
    endfunction

    // Days before the start of a March-based month (0 = March)
    function automatic logic [8:0] doy_lut(input logic [3:0] mm);
        logic [8:0] d;
        case (mm)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/countdown_time_difference_split_top.sv -----
// Top level of the countdown time difference splitter.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  item in   | start, busy        | current_year/month/day/hour/minute/second
//  config    | cfg_we             | cfg_index, cfg_data (12 bits)
//  result    | done (strobe)      | days_out, hours_out, minutes_out, seconds_out
//
// One item is accepted per cycle; busy is high only in the first cycle after reset.
// Each result strobes on done once its item has passed the registered stages in turn:
// input register, calendar conversion, difference, divide by 60, split and select.
// Results are shown for one cycle; the receiver cannot stall, so none is held back.
// Reset is asynchronous and active low; it restores the configuration defaults.
`include "countdown_time_difference_split_top_defines.svh"

module countdown_time_difference_split_top
    import cdts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] current_year,
    input  logic [3:0]  current_month,
    input  logic [4:0]  current_day,
    input  logic [4:0]  current_hour,
    input  logic [5:0]  current_minute,
    input  logic [5:0]  current_second,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        done,
    output logic [15:0] days_out,
    output logic [15:0] hours_out,
    output logic [15:0] minutes_out,
    output logic [15:0] seconds_out
);

    // ---------------- configuration registers
    logic [4:0]  display_mode_reg;
    logic [11:0] target_year_reg;
    logic [3:0]  target_month_reg;
    logic [4:0]  target_day_reg;
    logic [4:0]  target_hour_reg;
    logic [5:0]  target_minute_reg;
    logic [5:0]  target_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg  <= MODE_DHMS_LO;
            target_year_reg   <= 12'd2000;
            target_month_reg  <= 4'd1;
            target_day_reg    <= 5'd1;
            target_hour_reg   <= 5'd0;
            target_minute_reg <= 6'd0;
            target_second_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            // decode the index; indexes past the list are dropped
            unique case (cfg_index)
                REG_DISPLAY_MODE:  display_mode_reg  <= cfg_data[4:0];
                REG_TARGET_YEAR:   target_year_reg   <= cfg_data;
                REG_TARGET_MONTH:  target_month_reg  <= cfg_data[3:0];
                REG_TARGET_DAY:    target_day_reg    <= cfg_data[4:0];
                REG_TARGET_HOUR:   target_hour_reg   <= cfg_data[4:0];
                REG_TARGET_MINUTE: target_minute_reg <= cfg_data[5:0];
                REG_TARGET_SECOND: target_second_reg <= cfg_data[5:0];
                default:           display_mode_reg  <= display_mode_reg;
            endcase
        end
    end

    // ---------------- item acceptance: busy only right after reset
    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // ---------------- stage 0: input register
    logic        v0_reg;
    logic [11:0] cur_year_reg;
    logic [3:0]  cur_month_reg;
    logic [4:0]  cur_day_reg;
    logic [4:0]  cur_hour_reg;
    logic [5:0]  cur_minute_reg;
    logic [5:0]  cur_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    // hold the item fields; load only on an accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_year_reg   <= current_year;
            cur_month_reg  <= current_month;
            cur_day_reg    <= current_day;
            cur_hour_reg   <= current_hour;
            cur_minute_reg <= current_minute;
            cur_second_reg <= current_second;
        end
    end

    // ---------------- stage 1: calendar conversion of both instants
    stamp_t cur_stamp;
    stamp_t tgt_stamp;
    stamp_t cur_stamp_reg;
    stamp_t tgt_stamp_reg;
    logic   v1_reg;

    cdts_stamp u_stamp_cur (
        .year   (cur_year_reg),
        .month  (cur_month_reg),
        .day    (cur_day_reg),
        .hour   (cur_hour_reg),
        .minute (cur_minute_reg),
        .second (cur_second_reg),
        .stamp  (cur_stamp)
    );

    // the user changes the target only while idle (the block does not enforce it), so convert it alongside each item
    cdts_stamp u_stamp_tgt (
        .year   (target_year_reg),
        .month  (target_month_reg),
        .day    (target_day_reg),
        .hour   (target_hour_reg),
        .minute (target_minute_reg),
        .second (target_second_reg),
        .stamp  (tgt_stamp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_stamp_reg <= cur_stamp;
        tgt_stamp_reg <= tgt_stamp;
    end

    // ---------------- stages 2 to 4: difference, divide, split and result register
    cdts_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v1_reg),
        .cur         (cur_stamp_reg),
        .tgt         (tgt_stamp_reg),
        .mode        (display_mode_reg),
        .out_valid   (done),
        .days_val    (days_out),
        .hours_val   (hours_out),
        .minutes_val (minutes_out),
        .seconds_val (seconds_out)
    );

    // ---------------- assertions
    // modes whose hours stay within one day, and modes whose seconds stay within one minute
    logic hours_mode;
    logic secs_mode;

    assign hours_mode = (display_mode_reg <= MODE_DH_HI);
    assign secs_mode  = (display_mode_reg <= MODE_DHMS_HI) || (display_mode_reg == MODE_HMS)
                        || (display_mode_reg == MODE_MS);

    `CDTS_ASSERT_IMPL(a_done_has_item, clk, rst_n, done, $past(start && !busy, 5))
    `CDTS_ASSERT_NEXT(a_item_gets_done, clk, rst_n, start && !busy, ##4 done)
    `CDTS_ASSERT_IMPL(a_hours_in_day, clk, rst_n, done && $past(hours_mode), hours_out < 16'd24)
    `CDTS_ASSERT_IMPL(a_sec_in_min, clk, rst_n, done && $past(secs_mode), seconds_out < 16'd60)

endmodule

// ----- sv/cdts_stamp.sv -----
// Calendar time to day number and seconds-of-day conversion.
module cdts_stamp
    import cdts_pkg::*;
(
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    output stamp_t      stamp
);

    logic [3:0]  m_norm;
    logic [12:0] y_base;
    logic [12:0] y_adj;
    logic [3:0]  mm;
    logic [8:0]  doy;
    logic [10:0] y4;
    logic [6:0]  y100;
    logic [6:0]  y400;
    logic [20:0] y365;
    logic [20:0] day_sum;

    always_comb
    begin
        // carry month 0 and months past December into the year
        if (month == 4'd0)
        begin
            m_norm = 4'd12;
            y_base = {1'b0, year} + YEAR_BIAS - 13'd1;
        end
        else if (month > 4'd12)
        begin
            m_norm = month - 4'd12;
            y_base = {1'b0, year} + YEAR_BIAS + 13'd1;
        end
        else
        begin
            m_norm = month;
            y_base = {1'b0, year} + YEAR_BIAS;
        end

        // January and February count with the previous year
        y_adj = (m_norm <= 4'd2) ? y_base - 13'd1 : y_base;
        mm    = (m_norm > 4'd2) ? m_norm - 4'd3 : m_norm + 4'd9;
        doy   = doy_lut(mm);

        y4   = y_adj[12:2];
        y100 = div100(y_adj);
        y400 = div100({2'b00, y4});
        y365 = 21'(y_adj) * 21'd365;

        day_sum = y365 + 21'(y4) + 21'(y400) + 21'(doy) + 21'(day) - 21'(y100);
    end

    assign stamp.days = $signed({1'b0, day_sum}) - DAY_BIAS;
    assign stamp.sod  = 17'(hour) * SEC_PER_HOUR + 17'(minute) * SEC_PER_MIN + 17'(second);

endmodule

// ----- sv/cdts_split.sv -----
// Absolute difference of two instants and its split into display units.
module cdts_split
    import cdts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  stamp_t      cur,
    input  stamp_t      tgt,
    input  logic [4:0]  mode,
    output logic        out_valid,
    output logic [15:0] days_val,
    output logic [15:0] hours_val,
    output logic [15:0] minutes_val,
    output logic [15:0] seconds_val
);

    localparam logic [15:0]        RECIP_15    = 16'd34953;  // 2^19 / 15, rounded up
    localparam logic [11:0]        RECIP_60    = 12'd2185;   // 2^17 / 60, rounded up
    localparam logic [15:0]        DAY_WRAP    = 16'd20864;  // 86400 mod 2^16
    localparam logic [15:0]        HOURS_DAY   = 16'd24;
    localparam logic [15:0]        MINUTES_DAY = 16'd1440;
    localparam logic signed [18:0] DAY_SEC_S   = $signed({2'b00, SEC_PER_DAY});

    // ---------------- stage 2: difference, normalize, absolute value
    logic signed [22:0] dd;
    logic signed [22:0] dd_n;
    logic signed [18:0] ds;
    logic signed [18:0] ds_fix;
    logic [16:0]        ds_n;
    logic [22:0]        d_abs;
    logic [16:0]        s_abs;

    logic        v2_reg;
    logic [15:0] d2_reg;
    logic [16:0] s2_reg;

    always_comb
    begin
        dd = $signed({cur.days[21], cur.days}) - $signed({tgt.days[21], tgt.days});
        ds = $signed({2'b00, cur.sod}) - $signed({2'b00, tgt.sod});

        // fold the seconds into one day and move the carry into the day count
        if (ds < -DAY_SEC_S)
        begin
            ds_fix = ds + (DAY_SEC_S <<< 1);
            dd_n   = dd - 23'sd2;
        end
        else if (ds < 19'sd0)
        begin
            ds_fix = ds + DAY_SEC_S;
            dd_n   = dd - 23'sd1;
        end
        else if (ds >= DAY_SEC_S)
        begin
            ds_fix = ds - DAY_SEC_S;
            dd_n   = dd + 23'sd1;
        end
        else
        begin
            ds_fix = ds;
            dd_n   = dd;
        end
        ds_n = ds_fix[16:0];

        // negate the whole instant when the target lies ahead
        if (dd_n[22])
        begin
            if (ds_n == 17'd0)
            begin
                d_abs = 23'(-dd_n);
                s_abs = 17'd0;
            end
            else
            begin
                d_abs = ~dd_n;
                s_abs = SEC_PER_DAY - ds_n;
            end
        end
        else
        begin
            d_abs = dd_n;
            s_abs = ds_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d2_reg <= d_abs[15:0];
        s2_reg <= s_abs;
    end

    // ---------------- stage 3: seconds of day over 60
    logic [30:0] prod15;
    logic [10:0] q60;
    logic [16:0] rem60;

    logic        v3_reg;
    logic [15:0] d3_reg;
    logic [10:0] q3_reg;
    logic [5:0]  r3_reg;
    logic [15:0] s3_reg;

    always_comb
    begin
        prod15 = 31'(s2_reg[16:2]) * 31'(RECIP_15);
        q60    = prod15[29:19];
        rem60  = s2_reg - 17'(q60) * SEC_PER_MIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d3_reg <= d2_reg;
        q3_reg <= q60;
        r3_reg <= rem60[5:0];
        s3_reg <= s2_reg[15:0];
    end

    // ---------------- stage 4: hours, minutes, totals, mode select
    logic [22:0] prod60;
    logic [4:0]  hq;
    logic [10:0] mrem;
    logic [15:0] tot_h;
    logic [15:0] tot_m;
    logic [15:0] tot_s;
    logic [15:0] d_sel;
    logic [15:0] h_sel;
    logic [15:0] m_sel;
    logic [15:0] s_sel;

    logic        done_reg;
    logic [15:0] days_reg;
    logic [15:0] hours_reg;
    logic [15:0] minutes_reg;
    logic [15:0] seconds_reg;

    always_comb
    begin
        prod60 = 23'(q3_reg) * 23'(RECIP_60);
        hq     = prod60[21:17];
        mrem   = q3_reg - 11'(hq) * MIN_PER_HOUR;

        // totals wrap at 16 bits, so only the low day bits matter
        tot_h = d3_reg * HOURS_DAY + {11'd0, hq};
        tot_m = d3_reg * MINUTES_DAY + {5'd0, q3_reg};
        tot_s = d3_reg * DAY_WRAP + s3_reg;

        d_sel = 16'd0;
        h_sel = 16'd0;
        m_sel = 16'd0;
        s_sel = 16'd0;
        case (mode) inside
            [MODE_DHMS_LO:MODE_DHMS_HI]:
            begin
                d_sel = d3_reg;
                h_sel = {11'd0, hq};
                m_sel = {10'd0, mrem[5:0]};
                s_sel = {10'd0, r3_reg};
            end
            [MODE_DHM_LO:MODE_DHM_HI]:
            begin
                d_sel = d3_reg;
                h_sel = {11'd0, hq};
                m_sel = {10'd0, mrem[5:0]};
            end
            [MODE_DH_LO:MODE_DH_HI]:
            begin
                d_sel = d3_reg;
                h_sel = {11'd0, hq};
            end
            [MODE_D_LO:MODE_D_HI]:
            begin
                d_sel = d3_reg;
            end
            MODE_HMS:
            begin
                h_sel = tot_h;
                m_sel = {10'd0, mrem[5:0]};
                s_sel = {10'd0, r3_reg};
            end
            MODE_HM:
            begin
                h_sel = tot_h;
                m_sel = {10'd0, mrem[5:0]};
            end
            MODE_H:
            begin
                h_sel = tot_h;
            end
            MODE_MS:
            begin
                m_sel = tot_m;
                s_sel = {10'd0, r3_reg};
            end
            MODE_M:
            begin
                m_sel = tot_m;
            end
            MODE_S:
            begin
                s_sel = tot_s;
            end
            default:
            begin
                d_sel = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg    <= d_sel;
        hours_reg   <= h_sel;
        minutes_reg <= m_sel;
        seconds_reg <= s_sel;
    end

    assign out_valid   = done_reg;
    assign days_val    = days_reg;
    assign hours_val   = hours_reg;
    assign minutes_val = minutes_reg;
    assign seconds_val = seconds_reg;

endmodule

// ----- sim/countdown_time_difference_split_top_tb.sv -----
// Self-checking testbench for the countdown time difference splitter.
module countdown_time_difference_split_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdts_pkg::*;

    // One calendar time as the input ports carry it.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } clock_time_t;

    // One split difference as the result ports carry it.
    typedef struct packed {
        logic [15:0] days;
        logic [15:0] hours;
        logic [15:0] minutes;
        logic [15:0] seconds;
    } time_split_t;

    // Scoreboard: hold a copy of the registers, predict the split of every
    // accepted item and compare results in order against it.
    class split_scoreboard;
        logic [4:0]  cfg_mode;
        clock_time_t tgt;
        time_split_t pending_splits[$];
        int          errors;

        function new();
            cfg_mode = MODE_DHMS_LO;
            tgt      = '{year: 12'd2000, month: 4'd1, day: 5'd1,
                         hour: 5'd0, minute: 6'd0, second: 6'd0};
            errors   = 0;
        endfunction

        function void set_reg(logic [2:0] index, logic [11:0] value);
            case (index)
                REG_DISPLAY_MODE:  cfg_mode   = value[4:0];
                REG_TARGET_YEAR:   tgt.year   = value[11:0];
                REG_TARGET_MONTH:  tgt.month  = value[3:0];
                REG_TARGET_DAY:    tgt.day    = value[4:0];
                REG_TARGET_HOUR:   tgt.hour   = value[4:0];
                REG_TARGET_MINUTE: tgt.minute = value[5:0];
                REG_TARGET_SECOND: tgt.second = value[5:0];
                default: ;
            endcase
        endfunction

        // Signed seconds since 1970-01-01; months out of range carry into years,
        // days, hours, minutes and seconds out of range add linearly.
        function longint calendar_to_seconds(clock_time_t t);
            longint mt, y, m, era, yoe, doy, doe, days;
            longint yr, mo, dy, hr, mi, se;
            yr = t.year;
            mo = t.month;
            dy = t.day;
            hr = t.hour;
            mi = t.minute;
            se = t.second;
            // bias by 400 years so every division below sees a non-negative value
            mt = yr * 12 + mo - 1 + 12 * 400;
            y  = mt / 12;
            m  = mt % 12 + 1;
            if (m <= 2)
                y = y - 1;
            era  = y / 400;
            yoe  = y - era * 400;
            doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468 - 146097 + dy - 1;
            return days * 86400 + hr * 3600 + mi * 60 + se;
        endfunction

        function time_split_t split_difference(clock_time_t now_t);
            longint cur, dst;
            longint unsigned diff, rem, d, h, m, s;
            time_split_t r;
            cur = calendar_to_seconds(now_t);
            dst = calendar_to_seconds(tgt);
            diff = (cur > dst) ? longint'(cur - dst) : longint'(dst - cur);
            d = 0;
            h = 0;
            m = 0;
            s = 0;
            if (cfg_mode <= MODE_D_HI) begin
                d   = diff / SEC_PER_DAY;
                rem = diff % SEC_PER_DAY;
                if (cfg_mode <= MODE_DH_HI)
                    h = rem / SEC_PER_HOUR;
                if (cfg_mode <= MODE_DHM_HI)
                    m = (rem % SEC_PER_HOUR) / SEC_PER_MIN;
                if (cfg_mode <= MODE_DHMS_HI)
                    s = diff % SEC_PER_MIN;
            end
            else if (cfg_mode <= MODE_H) begin
                h = diff / SEC_PER_HOUR;
                if (cfg_mode <= MODE_HM)
                    m = (diff % SEC_PER_HOUR) / SEC_PER_MIN;
                if (cfg_mode == MODE_HMS)
                    s = diff % SEC_PER_MIN;
            end
            else if (cfg_mode <= MODE_M) begin
                m = diff / SEC_PER_MIN;
                if (cfg_mode == MODE_MS)
                    s = diff % SEC_PER_MIN;
            end
            else if (cfg_mode == MODE_S) begin
                s = diff;
            end
            // unknown modes leave all four fields zero
            r.days    = d[15:0];
            r.hours   = h[15:0];
            r.minutes = m[15:0];
            r.seconds = s[15:0];
            return r;
        endfunction

        function void note_item(clock_time_t t);
            pending_splits.push_back(split_difference(t));
        endfunction

        function void check_result(time_split_t got);
            time_split_t exp_r;
            if (pending_splits.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with no item pending: d=%0d h=%0d m=%0d s=%0d",
                             $realtime, got.days, got.hours, got.minutes, got.seconds);
                return;
            end
            exp_r = pending_splits.pop_front();
            if (got.days !== exp_r.days || got.hours !== exp_r.hours ||
                got.minutes !== exp_r.minutes || got.seconds !== exp_r.seconds) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp d=%0d h=%0d m=%0d s=%0d got d=%0d h=%0d m=%0d s=%0d",
                             $realtime, exp_r.days, exp_r.hours, exp_r.minutes,
                             exp_r.seconds, got.days, got.hours, got.minutes, got.seconds);
            end
        endfunction

        function int pending();
            return pending_splits.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [11:0] current_year;
    logic [3:0]  current_month;
    logic [4:0]  current_day;
    logic [4:0]  current_hour;
    logic [5:0]  current_minute;
    logic [5:0]  current_second;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        done;
    logic [15:0] days_out;
    logic [15:0] hours_out;
    logic [15:0] minutes_out;
    logic [15:0] seconds_out;

    split_scoreboard sb;
    bit              no_idle;

    countdown_time_difference_split_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .current_year   (current_year),
        .current_month  (current_month),
        .current_day    (current_day),
        .current_hour   (current_hour),
        .current_minute (current_minute),
        .current_second (current_second),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .days_out       (days_out),
        .hours_out      (hours_out),
        .minutes_out    (minutes_out),
        .seconds_out    (seconds_out)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sample both channels at the rising edge, before the block's own updates
    // land. Results are checked first; an item accepted at this same edge
    // belongs behind them in the queue.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done)
                sb.check_result('{days: days_out, hours: hours_out,
                                  minutes: minutes_out, seconds: seconds_out});
            if (start && !busy)
                sb.note_item('{year: current_year, month: current_month,
                               day: current_day, hour: current_hour,
                               minute: current_minute, second: current_second});
        end
    end

    // Write one register at a falling edge; keep the model copy in step.
    task automatic write_reg(input logic [2:0] index, input logic [11:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        sb.set_reg(index, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_target(input clock_time_t t);
        write_reg(REG_TARGET_YEAR,   t.year);
        write_reg(REG_TARGET_MONTH,  12'(t.month));
        write_reg(REG_TARGET_DAY,    12'(t.day));
        write_reg(REG_TARGET_HOUR,   12'(t.hour));
        write_reg(REG_TARGET_MINUTE, 12'(t.minute));
        write_reg(REG_TARGET_SECOND, 12'(t.second));
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_item(input clock_time_t t);
        @(negedge clk);
        start          = 1'b1;
        current_year   = t.year;
        current_month  = t.month;
        current_day    = t.day;
        current_hour   = t.hour;
        current_minute = t.minute;
        current_second = t.second;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and hold it low; n gives the gap length, zero for none.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Drop start, wait for every expected result, then let the pipeline
    // settle before any register changes.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic clock_time_t full_width_time();
        clock_time_t t;
        t = clock_time_t'({$urandom, $urandom});
        return t;
    endfunction

    function automatic clock_time_t valid_time();
        clock_time_t t;
        t.year   = 12'($urandom_range(1970, 2099));
        t.month  = 4'($urandom_range(1, 12));
        t.day    = 5'($urandom_range(1, 31));
        t.hour   = 5'($urandom_range(0, 23));
        t.minute = 6'($urandom_range(0, 59));
        t.second = 6'($urandom_range(0, 59));
        return t;
    endfunction

    // Mix of ordinary times, times close to the target, and raw bit patterns.
    function automatic clock_time_t random_item();
        clock_time_t t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            t = valid_time();
        end
        else if (r < 85) begin
            t = sb.tgt;
            t.second = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 1))
                t.minute = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 2) == 0)
                t.hour = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0)
                t.day = 5'($urandom_range(0, 31));
        end
        else begin
            t = full_width_time();
        end
        return t;
    endfunction

    function automatic clock_time_t mk_time(int y, int mo, int d, int h, int mi, int s);
        clock_time_t t;
        t.year   = 12'(y);
        t.month  = 4'(mo);
        t.day    = 5'(d);
        t.hour   = 5'(h);
        t.minute = 6'(mi);
        t.second = 6'(s);
        return t;
    endfunction

    // Hard limit on run time.
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        clock_time_t t;
        int          n_items;
        logic [4:0]  mode_val;

        sb             = new();
        rst_n          = 1'b0;
        start          = 1'b0;
        current_year   = '0;
        current_month  = '0;
        current_day    = '0;
        current_hour   = '0;
        current_minute = '0;
        current_second = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        no_idle        = 1'b1;

        // Hold reset low, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items against the reset configuration: equal to the target,
        // both ends of the normal year range, all-zero and all-one fields,
        // month 0 and month 13 carries, day 0, hour 24, and a pre-1970 instant.
        send_item(mk_time(2000, 1, 1, 0, 0, 0));
        send_item(mk_time(1970, 1, 1, 0, 0, 0));
        send_item(mk_time(2099, 12, 31, 23, 59, 59));
        send_item(mk_time(0, 0, 0, 0, 0, 0));
        send_item(mk_time(4095, 15, 31, 31, 63, 63));
        send_item(mk_time(2000, 0, 1, 0, 0, 0));
        send_item(mk_time(1999, 13, 1, 0, 0, 0));
        send_item(mk_time(2000, 3, 0, 24, 0, 0));
        send_item(mk_time(1969, 12, 31, 23, 59, 59));
        drain();

        // Visit every display mode, plus two unknown codes, with one wide
        // difference so the 16-bit wrap of hours and minutes shows up.
        for (int m = 0; m <= 19; m++) begin
            mode_val = (m == 19) ? 5'd31 : 5'(m);
            write_reg(REG_DISPLAY_MODE, 12'(mode_val));
            send_item(mk_time(2099, 12, 31, 23, 59, 59));
            drain();
        end

        // Random phases, each under a fresh configuration. The first two use
        // the all-zero and all-one register extremes.
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0) begin
                write_reg(REG_DISPLAY_MODE, 12'(MODE_DHMS_LO));
                write_target(mk_time(0, 0, 0, 0, 0, 0));
            end
            else if (phase == 1) begin
                write_reg(REG_DISPLAY_MODE, 12'h01F);
                write_target(mk_time(4095, 15, 31, 31, 63, 63));
            end
            else begin
                if ($urandom_range(0, 3) == 0)
                    mode_val = 5'($urandom_range(18, 31));
                else
                    mode_val = 5'($urandom_range(0, 17));
                write_reg(REG_DISPLAY_MODE, 12'(mode_val));
                write_target(($urandom_range(0, 4) == 0) ? full_width_time() : valid_time());
            end

            // Run roughly one phase in four back to back with no gaps.
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(120, 150);
            for (int i = 0; i < n_items; i++) begin
                idle_cycles(gap_len());
                t = random_item();
                send_item(t);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cdts_pkg.sv
sv/cdts_stamp.sv
sv/cdts_split.sv
sv/countdown_time_difference_split_top.sv
sim/countdown_time_difference_split_top_tb.sv
